// ===== hdl/lps_pkg.sv =====
`default_nettype none
package lps_pkg;

   localparam int NUM_LEDS   = 20;
   localparam int LED_W      = $clog2(NUM_LEDS);
   localparam int LVL_W      = 4;
   localparam int MODE_W     = 2;
   localparam int PERIOD_W   = 8;
   localparam int PHASE_W    = ($clog2(NUM_LEDS + 1) > 5) ? $clog2(NUM_LEDS + 1) : 5;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = ((LED_W + LVL_W + 7) / 8) * 8;
   localparam int SCAN_TAPS  = 7;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam bit LED_ODD    = (NUM_LEDS % 2) == 1;

   localparam logic [MODE_W-1:0] MODE_OFF       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCANNER   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PULSE     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ALTERNATE = 2'd3;

   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_BUTTON = 1'b1;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_NEXT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SCANNER_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_PERIOD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALTERNATE_PERIOD = 2'd2;

   localparam logic [LVL_W-1:0] LVL_MAX = 4'd15;

   // classified event between front end and sequencer
   typedef struct packed {
      logic valid;
      logic cmd;
   } cmd_type;

   // scanner brightness for tap k (offset k-4 from phase)
   function automatic logic [LVL_W-1:0] scan_level(input logic [2:0] k);
      logic [LVL_W-1:0] r;
      case (k)
         3'd0: r = 4'd0;
         3'd1: r = 4'd1;
         3'd2: r = 4'd4;
         3'd3: r = 4'd15;
         3'd4: r = 4'd4;
         3'd5: r = 4'd1;
         3'd6: r = 4'd0;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // two ramps up and down over phases 0..19, dark after
   function automatic logic [LVL_W-1:0] pulse_level(input logic [PHASE_W-1:0] s);
      logic [PHASE_W-1:0] r;
      logic               up;
      logic               dark;
      logic [3:0]         t;
      r    = s;
      up   = 1'b1;
      dark = 1'b0;
      if (s < PHASE_W'(5)) begin
         r  = s;
         up = 1'b1;
      end else if (s < PHASE_W'(10)) begin
         r  = s - PHASE_W'(5);
         up = 1'b0;
      end else if (s < PHASE_W'(15)) begin
         r  = s - PHASE_W'(10);
         up = 1'b1;
      end else if (s < PHASE_W'(20)) begin
         r  = s - PHASE_W'(15);
         up = 1'b0;
      end else begin
         dark = 1'b1;
      end
      if (up) t = {1'b0, r[2:0]} + 4'd1;
      else    t = 4'd5 - {1'b0, r[2:0]};
      return dark ? 4'd0 : 4'(t * 4'd3);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/lps_front.sv =====
`default_nettype none
module lps_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [lps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                             req_tuser,
   input  wire logic                             q_full,
   output lps_pkg::cmd_type                      push
);

   logic last_btn_ff;
   logic last_btn_in;
   logic accept;
   logic btn;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign btn        = req_tdata[0];

   // ticks always go on; button samples only matter on a change, and only
   // a falling level steps the mode
   always_comb begin
      last_btn_in = last_btn_ff;
      push.valid  = 1'b0;
      push.cmd    = lps_pkg::CMD_TICK;
      if (accept) begin
         if (req_tuser == lps_pkg::REQ_TICK) begin
            push.valid = 1'b1;
         end else if (btn != last_btn_ff) begin
            last_btn_in = btn;
            push.valid  = !btn;
            push.cmd    = lps_pkg::CMD_NEXT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_btn_ff <= 1'b0;
      end else begin
         last_btn_ff <= last_btn_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lps_cmd_queue.sv =====
`default_nettype none
module lps_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lps_pkg::cmd_type push,
   output logic                  full,
   output lps_pkg::cmd_type      head,
   input  wire logic             pop
);

   logic                             cmd_ff [lps_pkg::CMDQ_DEPTH];
   logic [lps_pkg::CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lps_pkg::CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lps_pkg::CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full       = count_ff == lps_pkg::CMDQ_CNT_W'(lps_pkg::CMDQ_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = cmd_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == lps_pkg::CMDQ_PTR_W'(lps_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lps_pkg::CMDQ_PTR_W'(lps_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) cmd_ff[wr_ptr_ff] <= push.cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lps_sequencer.sv =====
`default_nettype none
module lps_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [lps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lps_pkg::PERIOD_W-1:0]      csr_wdata,
   input  wire lps_pkg::cmd_type                  cmd_in,
   output logic                                   cmd_pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lps_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [lps_pkg::MODE_W-1:0]             rsp_tuser,
   output logic                                   rsp_tlast
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   localparam int LW = lps_pkg::LED_W;
   localparam int PW = lps_pkg::PHASE_W;
   localparam int VW = PW + 2;
   localparam logic [LW-1:0] LAST_LED = LW'(lps_pkg::NUM_LEDS - 1);

   // config
   logic [lps_pkg::PERIOD_W-1:0] scan_per_ff, pulse_per_ff, alt_per_ff;

   // sequencer state
   logic [1:0]                   state_ff, state_in;
   logic [lps_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [PW-1:0]                phase_ff, phase_in;
   logic                         backward_ff, backward_in;
   logic [lps_pkg::PERIOD_W-1:0] tick_ff, tick_in;
   logic                         due_ff, due_in;
   logic [LW-1:0]                idx_ff, idx_in;

   // frame job captured at decode
   logic [lps_pkg::MODE_W-1:0]   sw_mode_ff, sw_mode_in;
   logic [lps_pkg::LVL_W-1:0]    lvl_ff, lvl_in;
   logic [LW-1:0]                pos_ff [lps_pkg::SCAN_TAPS];
   logic [LW-1:0]                pos_in [lps_pkg::SCAN_TAPS];
   logic [lps_pkg::SCAN_TAPS-1:0] en_ff, en_in;

   // frame memory
   logic [lps_pkg::LVL_W-1:0]    mem [lps_pkg::NUM_LEDS];
   logic [lps_pkg::LVL_W-1:0]    mem_q_ff;
   logic                         vq_ff;
   logic [lps_pkg::NUM_LEDS-1:0] vld_ff;
   logic                         rd_en;
   logic [LW-1:0]                rd_addr;
   logic                         wr_en;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                rsp_idx_ff;
   logic [lps_pkg::LVL_W-1:0]    rsp_lvl_ff;
   logic [lps_pkg::MODE_W-1:0]   rsp_mode_ff;
   logic                         rsp_last_ff;

   logic                         out_free;
   logic [lps_pkg::PERIOD_W-1:0] period;
   logic [lps_pkg::PERIOD_W-1:0] tick_inc;
   logic                         due_now;
   logic [PW:0]                  scan_next;
   logic                         scan_flip;
   logic [lps_pkg::LVL_W-1:0]    old_lvl;
   logic [lps_pkg::LVL_W-1:0]    new_lvl;
   logic [lps_pkg::MODE_W-1:0]   mode_step;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lps_pkg::RSP_DATA_W'({rsp_lvl_ff, rsp_idx_ff});
   assign rsp_tuser  = rsp_mode_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_in.valid;
   assign mode_step  = mode_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_per_ff  <= 8'd8;
         pulse_per_ff <= 8'd8;
         alt_per_ff   <= 8'd25;
      end else if (csr_we) begin
         case (csr_index)
            lps_pkg::CSR_SCANNER_PERIOD:   scan_per_ff  <= csr_wdata;
            lps_pkg::CSR_PULSE_PERIOD:     pulse_per_ff <= csr_wdata;
            lps_pkg::CSR_ALTERNATE_PERIOD: alt_per_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (mode_ff)
         lps_pkg::MODE_SCANNER:   period = scan_per_ff;
         lps_pkg::MODE_PULSE:     period = pulse_per_ff;
         lps_pkg::MODE_ALTERNATE: period = alt_per_ff;
         default:                 period = '0;
      endcase
   end

   assign tick_inc = (tick_ff != '1) ? tick_ff + 1'b1 : tick_ff;
   assign due_now  = due_ff || ((period != '0) && (tick_inc >= period));

   // scanner bounce: clamp into 0..NUM_LEDS and turn at either end
   always_comb begin
      scan_flip = 1'b0;
      if (backward_ff) begin
         if (phase_ff == '0) begin
            scan_next = '0;
            scan_flip = 1'b1;
         end else begin
            scan_next = {1'b0, phase_ff} - 1'b1;
            scan_flip = scan_next == '0;
         end
      end else begin
         scan_next = {1'b0, phase_ff} + 1'b1;
         if (scan_next >= (PW + 1)'(lps_pkg::NUM_LEDS)) begin
            scan_flip = 1'b1;
            scan_next = (PW + 1)'(lps_pkg::NUM_LEDS);
         end
      end
   end

   // scanner taps at phase-4 .. phase+2, wrapped around the strip
   always_comb begin
      logic signed [VW-1:0] v;
      for (int k = 0; k < lps_pkg::SCAN_TAPS; k++) begin
         v = $signed({2'b00, phase_ff}) + $signed(VW'(k - 4));
         if (v < 0) v = v + $signed(VW'(lps_pkg::NUM_LEDS));
         else if (v >= $signed(VW'(lps_pkg::NUM_LEDS))) v = v - $signed(VW'(lps_pkg::NUM_LEDS));
         pos_in[k] = v[LW-1:0];
      end
      en_in[0] = phase_ff > PW'(2);
      en_in[1] = phase_ff > PW'(1);
      en_in[2] = phase_ff > PW'(0);
      en_in[3] = 1'b1;
      en_in[4] = phase_ff < PW'(lps_pkg::NUM_LEDS);
      en_in[5] = phase_ff < PW'(lps_pkg::NUM_LEDS - 1);
      en_in[6] = phase_ff < PW'(lps_pkg::NUM_LEDS - 2);
   end

   // command decode and sweep control
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      backward_in = backward_ff;
      tick_in     = tick_ff;
      due_in      = due_ff;
      idx_in      = idx_ff;
      sw_mode_in  = sw_mode_ff;
      lvl_in      = lvl_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_in.valid) begin
               if (cmd_in.cmd == lps_pkg::CMD_NEXT) begin
                  phase_in    = '0;
                  backward_in = 1'b0;
                  mode_in     = mode_step;
                  if (mode_step == lps_pkg::MODE_OFF) begin
                     sw_mode_in = lps_pkg::MODE_OFF;
                     idx_in     = '0;
                     state_in   = ST_FETCH;
                  end
               end else if (due_now && (mode_ff != lps_pkg::MODE_OFF)) begin
                  due_in     = 1'b0;
                  tick_in    = '0;
                  sw_mode_in = mode_ff;
                  idx_in     = '0;
                  state_in   = ST_FETCH;
                  case (mode_ff)
                     lps_pkg::MODE_SCANNER: begin
                        phase_in    = scan_next[PW-1:0];
                        backward_in = backward_ff ^ scan_flip;
                     end
                     lps_pkg::MODE_PULSE: begin
                        lvl_in   = lps_pkg::pulse_level(phase_ff);
                        phase_in = (phase_ff >= PW'(29)) ? '0 : phase_ff + 1'b1;
                     end
                     default: begin
                        lvl_in   = phase_ff[lps_pkg::LVL_W-1:0];
                        phase_in = PW'(lps_pkg::LVL_MAX - phase_ff[lps_pkg::LVL_W-1:0]);
                     end
                  endcase
               end else begin
                  due_in  = due_now;
                  tick_in = due_ff ? tick_ff : tick_inc;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (out_free) begin
               if (idx_ff == LAST_LED) state_in = ST_IDLE;
               else                    idx_in   = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // level of the LED under the sweep; later taps win on overlap
   always_comb begin
      old_lvl = vq_ff ? mem_q_ff : '0;
      case (sw_mode_ff)
         lps_pkg::MODE_SCANNER: begin
            new_lvl = old_lvl;
            for (int k = 0; k < lps_pkg::SCAN_TAPS; k++) begin
               if (en_ff[k] && (pos_ff[k] == idx_ff)) new_lvl = lps_pkg::scan_level(3'(k));
            end
         end
         lps_pkg::MODE_PULSE: begin
            new_lvl = lvl_ff;
         end
         lps_pkg::MODE_ALTERNATE: begin
            if (lps_pkg::LED_ODD && (idx_ff == LAST_LED)) new_lvl = old_lvl;
            else if (idx_ff[0])                           new_lvl = lps_pkg::LVL_MAX - lvl_ff;
            else                                          new_lvl = lvl_ff;
         end
         default: begin
            new_lvl = '0;
         end
      endcase
   end

   assign wr_en   = (state_ff == ST_SWEEP) && out_free;
   assign rd_en   = (state_ff == ST_FETCH) || (wr_en && (idx_ff != LAST_LED));
   assign rd_addr = (state_ff == ST_FETCH) ? idx_ff : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) mem[idx_ff] <= new_lvl;
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         vq_ff    <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wr_en)           rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_idx_ff  <= idx_ff;
         rsp_lvl_ff  <= new_lvl;
         rsp_mode_ff <= sw_mode_ff;
         rsp_last_ff <= idx_ff == LAST_LED;
      end
      if (state_ff == ST_IDLE) begin
         sw_mode_ff <= sw_mode_in;
         lvl_ff     <= lvl_in;
         en_ff      <= en_in;
         for (int k = 0; k < lps_pkg::SCAN_TAPS; k++) pos_ff[k] <= pos_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= lps_pkg::MODE_SCANNER;
         phase_ff     <= '0;
         backward_ff  <= 1'b0;
         tick_ff      <= '0;
         due_ff       <= 1'b1;
         idx_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         backward_ff  <= backward_in;
         tick_ff      <= tick_in;
         due_ff       <= due_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) vld_ff[idx_ff] <= 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/led_pattern_sequencer_top.sv =====
// A word that yields a frame passes the command queue, the decode and the memory
// fetch before its first LED word is registered at the output, then one LED word
// per cycle while rsp_tready is high. The sequencer takes no new command until a
// frame's sweep ends; other ticks and mode steps end at the decode, and button
// samples that step nothing never leave the front end.
// Reset (synchronous, high): scanner mode, frame all zero, first tick emits a frame.
`default_nettype none
module led_pattern_sequencer_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [lps_pkg::REQ_DATA_W-1:0]    req_tdata,  // [0] button_level
   input  wire logic                              req_tuser,  // [0] req_type: 0 tick, 1 button
   // response channel, one word per LED, LED 0 first
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lps_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // [LED_W-1:0] led_index, then level
   output logic [lps_pkg::MODE_W-1:0]             rsp_tuser,  // mode
   output logic                                   rsp_tlast,  // last_in_frame
   // period registers
   input  wire logic                              csr_we,
   input  wire logic [lps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lps_pkg::PERIOD_W-1:0]      csr_wdata
);

   lps_pkg::cmd_type push;
   lps_pkg::cmd_type head;
   logic             q_full;
   logic             q_pop;

   // front end: takes request words while the queue is not full, drops button samples
   // that do not change the level, turns falling levels into mode steps
   lps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push)
   );

   // short command queue so the front keeps taking words during a frame sweep until it fills
   lps_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (q_pop)
   );

   // mode/tick state, frame memory sweep and output register
   lps_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_in     (head),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== hdl/lps_checker.sv =====
`default_nettype none
module lps_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [lps_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic [lps_pkg::MODE_W-1:0]        rsp_tuser,
   input wire logic                              rsp_tlast
);

   logic [lps_pkg::LED_W-1:0] led;
   logic                      rsp_take;

   assign led      = rsp_tdata[lps_pkg::LED_W-1:0];
   assign rsp_take = rsp_tvalid && rsp_tready;

   a_out_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (led == lps_pkg::LED_W'(lps_pkg::NUM_LEDS - 1))))
      else $error("tlast not on final LED");

   a_frame_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_tlast) |=>
         (rsp_tvalid && (led == $past(led) + 1'b1) && $stable(rsp_tuser)))
      else $error("frame words not back to back in LED order");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("response changed while stalled");

endmodule

bind led_pattern_sequencer_top lps_checker u_lps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
